>>> rtl/likelihood_grid_search_unit_assert.svh
// Assertion macros used by the checker of the likelihood grid search unit.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef LIKELIHOOD_GRID_SEARCH_UNIT_ASSERT_SVH
`define LIKELIHOOD_GRID_SEARCH_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LGS_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define LGS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/lgs_pkg.sv
package lgs_pkg;

    localparam int TABLE_DEPTH   = 65536;
    localparam int TABLE_AW      = 16;
    localparam int MAX_TANKS     = 128;
    localparam int TANK_AW       = 7;
    localparam int MAX_GRID      = 1024;
    localparam int GRID_AW       = 10;
    localparam int MAX_DIST_BINS = 32;
    localparam int EDGE_DEPTH    = MAX_DIST_BINS + 1;
    localparam int EDGE_AW       = 6;
    localparam int DBIN_W        = 5;
    localparam int MAX_ENERGY    = 64;
    localparam int GRID_HEIGHT   = 124608;
    localparam int FRAC_BITS     = 14;
    localparam int ROUND_HALF    = 8192;

    typedef enum logic [2:0] {
        REQ_TABLE = 3'd0,
        REQ_EDGE  = 3'd1,
        REQ_TANK  = 3'd2,
        REQ_GRID  = 3'd3,
        REQ_START = 3'd4
    } req_t;

    typedef enum logic [2:0] {
        CFG_ENERGY_BINS   = 3'd0,
        CFG_FIRST_BINS    = 3'd1,
        CFG_SECOND_BINS   = 3'd2,
        CFG_DISTANCE_BINS = 3'd3,
        CFG_DIR_X         = 3'd4,
        CFG_DIR_Y         = 3'd5,
        CFG_DIR_Z         = 3'd6
    } cfg_t;

    typedef struct packed {
        logic        [2:0]  req_type;
        logic        [15:0] item_index;
        logic signed [31:0] llh_value;
        logic        [19:0] edge_value;
        logic signed [19:0] pos_x;
        logic signed [19:0] pos_y;
        logic signed [19:0] pos_z;
        logic        [5:0]  tank_bin_one;
        logic        [5:0]  tank_bin_two;
        logic        [7:0]  tank_count;
        logic        [10:0] grid_count;
    } lgs_in_t;

    typedef struct packed {
        logic signed [39:0] best_llh;
        logic        [9:0]  best_grid_index;
        logic        [5:0]  best_energy_bin;
        logic               found;
        logic               index_error;
    } lgs_out_t;

endpackage

>>> rtl/likelihood_grid_search_unit.sv
// Likelihood grid search unit. Load items (table words, distance edges, tanks,
// grid points) are taken one per cycle while busy is low and write straight into
// on-chip memories. A start item runs the search and holds busy high until it is
// done; the single result then appears for exactly one cycle with done high, and
// the receiver cannot stall it, so it must capture the result in that cycle.
// A search walks every grid point. For each it first runs the per-tank distance
// sequencer: seven arithmetic steps, then edge compares through the edge memory,
// each of which reads an edge, squares it and compares; a tank needs one more
// compare than the edges its squared distance passes, at most D - 1 for D
// distance bins and none for a single bin. Then the table walk, for each energy
// bin and tank, does the address multiplies and the registered read of the
// table memory.
// The memories have no reset; entries that were never loaded read as undefined.
// Configuration must be written only while the unit is idle; the unit does not enforce it.
module likelihood_grid_search_unit
    import lgs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  lgs_in_t     item,
    output logic        busy,
    output logic        done,
    output lgs_out_t    result,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    typedef enum logic [4:0] {
        S_IDLE,
        S_G_LOAD,
        S_T_RD,
        S_T_H,
        S_T_P1,
        S_T_S,
        S_T_P2,
        S_T_W,
        S_T_SQ,
        S_T_D,
        S_E_RD,
        S_E_SQ,
        S_E_CMP,
        S_T_WR,
        S_A_RD,
        S_A_1,
        S_A_2,
        S_A_3,
        S_L_RD,
        S_L_ACC,
        S_BEST,
        S_FINISH
    } state_t;

    state_t state_reg;

    // Configuration registers.
    logic        [6:0]  energy_bins_reg;
    logic        [6:0]  first_bins_reg;
    logic        [6:0]  second_bins_reg;
    logic        [5:0]  dist_bins_reg;
    logic signed [15:0] dir_x_reg;
    logic signed [15:0] dir_y_reg;
    logic signed [15:0] dir_z_reg;

    // Search control.
    logic [7:0]        nt_reg;
    logic [10:0]       ng_reg;
    logic [10:0]       g_cnt_reg;
    logic [7:0]        t_cnt_reg;
    logic [6:0]        e_cnt_reg;
    logic [DBIN_W-1:0] bin_reg;
    logic signed [39:0] sum_reg;
    logic signed [39:0] best_reg;
    logic [9:0]        best_g_reg;
    logic [5:0]        best_e_reg;
    logic              found_reg;
    logic              ierr_reg;
    logic              done_reg;
    lgs_out_t          result_reg;

    // Distance datapath.
    logic signed [20:0] hx_reg, hy_reg, hz_reg;
    logic signed [36:0] px_reg, py_reg, pz_reg;
    logic signed [25:0] s_reg;
    logic signed [41:0] qx_reg, qy_reg, qz_reg;
    logic signed [28:0] wx_reg, wy_reg, wz_reg;
    logic        [57:0] sqx_reg, sqy_reg, sqz_reg;
    logic        [59:0] d2_reg;
    logic        [39:0] esq_reg;

    // Table address datapath.
    logic [13:0] a1_reg;
    logic [21:0] a2_reg;
    logic [29:0] a3_reg;

    // Memories and their registered read data.
    logic signed [31:0] llh_mem [TABLE_DEPTH];
    logic        [19:0] edge_mem [EDGE_DEPTH];
    logic        [59:0] tank_mem [MAX_TANKS];
    logic        [11:0] bins_mem [MAX_TANKS];
    logic        [39:0] grid_mem [MAX_GRID];
    logic [DBIN_W-1:0]  dbin_mem [MAX_TANKS];

    logic signed [31:0] llh_q;
    logic        [19:0] edge_q;
    logic        [59:0] tank_q;
    logic        [11:0] bins_q;
    logic        [39:0] grid_q;
    logic [DBIN_W-1:0]  dbin_q;

    logic               accept;
    logic               llh_we, edge_we, tank_we, grid_we;
    logic [6:0]         ne;
    logic [5:0]         nd;
    logic [7:0]         nt_start;
    logic [10:0]        ng_start;
    logic [TANK_AW-1:0] t_idx;
    logic [EDGE_AW-1:0] edge_addr;
    logic signed [19:0] gx, gy, tx, ty, tz;
    logic        [5:0]  b1, b2;

    assign busy      = (state_reg != S_IDLE);
    assign done      = done_reg;
    assign result    = result_reg;
    assign cfg_ready = 1'b1;

    assign accept  = start && !busy;
    assign llh_we  = accept && (item.req_type == REQ_TABLE)
                     && (17'(item.item_index) < 17'(TABLE_DEPTH));
    assign edge_we = accept && (item.req_type == REQ_EDGE)
                     && (item.item_index < 16'(EDGE_DEPTH));
    assign tank_we = accept && (item.req_type == REQ_TANK)
                     && (item.item_index < 16'(MAX_TANKS));
    assign grid_we = accept && (item.req_type == REQ_GRID)
                     && (item.item_index < 16'(MAX_GRID));

    // Effective sizes: energy bins saturate at the table limit, a distance bin
    // count of zero acts as one, and counts above the store depths saturate.
    assign ne = (energy_bins_reg > 7'(MAX_ENERGY)) ? 7'(MAX_ENERGY) : energy_bins_reg;
    assign nd = (dist_bins_reg == 6'd0) ? 6'd1 :
                (dist_bins_reg > 6'(MAX_DIST_BINS)) ? 6'(MAX_DIST_BINS) : dist_bins_reg;
    assign nt_start = (item.tank_count > 8'(MAX_TANKS)) ? 8'(MAX_TANKS) : item.tank_count;
    assign ng_start = (item.grid_count > 11'(MAX_GRID)) ? 11'(MAX_GRID) : item.grid_count;

    assign t_idx     = t_cnt_reg[TANK_AW-1:0];
    assign edge_addr = EDGE_AW'(bin_reg) + EDGE_AW'(1);

    assign gx = grid_q[39:20];
    assign gy = grid_q[19:0];
    assign tx = tank_q[59:40];
    assign ty = tank_q[39:20];
    assign tz = tank_q[19:0];
    assign b1 = bins_q[11:6];
    assign b2 = bins_q[5:0];

    // Memories: one write port fed by load items or the distance sequencer,
    // one registered read port addressed by the search counters.
    always_ff @(posedge clk)
    begin
        if (llh_we)
        begin
            llh_mem[item.item_index[TABLE_AW-1:0]] <= item.llh_value;
        end
        llh_q <= llh_mem[a3_reg[TABLE_AW-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (edge_we)
        begin
            edge_mem[item.item_index[EDGE_AW-1:0]] <= item.edge_value;
        end
        edge_q <= edge_mem[edge_addr];
    end

    always_ff @(posedge clk)
    begin
        if (tank_we)
        begin
            tank_mem[item.item_index[TANK_AW-1:0]] <= {item.pos_x, item.pos_y, item.pos_z};
            bins_mem[item.item_index[TANK_AW-1:0]] <= {item.tank_bin_one, item.tank_bin_two};
        end
        tank_q <= tank_mem[t_idx];
        bins_q <= bins_mem[t_idx];
    end

    always_ff @(posedge clk)
    begin
        if (grid_we)
        begin
            grid_mem[item.item_index[GRID_AW-1:0]] <= {item.pos_x, item.pos_y};
        end
        grid_q <= grid_mem[g_cnt_reg[GRID_AW-1:0]];
    end

    // Distance bin of every tank for the current grid point.
    always_ff @(posedge clk)
    begin
        if (state_reg == S_T_WR)
        begin
            dbin_mem[t_idx] <= bin_reg;
        end
        dbin_q <= dbin_mem[t_idx];
    end

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            energy_bins_reg <= 7'd1;
            first_bins_reg  <= 7'd1;
            second_bins_reg <= 7'd1;
            dist_bins_reg   <= 6'd1;
            dir_x_reg       <= 16'sd0;
            dir_y_reg       <= 16'sd0;
            dir_z_reg       <= -16'sd16384;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_ENERGY_BINS:   energy_bins_reg <= cfg_data[6:0];
                CFG_FIRST_BINS:    first_bins_reg  <= cfg_data[6:0];
                CFG_SECOND_BINS:   second_bins_reg <= cfg_data[6:0];
                CFG_DISTANCE_BINS: dist_bins_reg   <= cfg_data[5:0];
                CFG_DIR_X:         dir_x_reg       <= cfg_data;
                CFG_DIR_Y:         dir_y_reg       <= cfg_data;
                CFG_DIR_Z:         dir_z_reg       <= cfg_data;
                default:           ;
            endcase
        end
    end

    // Arithmetic steps. The closest approach is w = round(s*e - h) with
    // s = round(e.h); both roundings are half up at 2^14 scale, which is an
    // arithmetic shift after adding half an LSB.
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_T_H:
            begin
                hx_reg <= 21'(gx) - 21'(tx);
                hy_reg <= 21'(gy) - 21'(ty);
                hz_reg <= 21'(GRID_HEIGHT) - 21'(tz);
            end
            S_T_P1:
            begin
                px_reg <= 37'(dir_x_reg) * 37'(hx_reg);
                py_reg <= 37'(dir_y_reg) * 37'(hy_reg);
                pz_reg <= 37'(dir_z_reg) * 37'(hz_reg);
            end
            S_T_S:
            begin
                s_reg <= 26'((39'(px_reg) + 39'(py_reg) + 39'(pz_reg)
                              + 39'(ROUND_HALF)) >>> FRAC_BITS);
            end
            S_T_P2:
            begin
                qx_reg <= 42'(s_reg) * 42'(dir_x_reg);
                qy_reg <= 42'(s_reg) * 42'(dir_y_reg);
                qz_reg <= 42'(s_reg) * 42'(dir_z_reg);
            end
            S_T_W:
            begin
                wx_reg <= 29'((43'(qx_reg) - (43'(hx_reg) <<< FRAC_BITS)
                               + 43'(ROUND_HALF)) >>> FRAC_BITS);
                wy_reg <= 29'((43'(qy_reg) - (43'(hy_reg) <<< FRAC_BITS)
                               + 43'(ROUND_HALF)) >>> FRAC_BITS);
                wz_reg <= 29'((43'(qz_reg) - (43'(hz_reg) <<< FRAC_BITS)
                               + 43'(ROUND_HALF)) >>> FRAC_BITS);
            end
            S_T_SQ:
            begin
                sqx_reg <= 58'(58'(wx_reg) * 58'(wx_reg));
                sqy_reg <= 58'(58'(wy_reg) * 58'(wy_reg));
                sqz_reg <= 58'(58'(wz_reg) * 58'(wz_reg));
            end
            S_T_D:
            begin
                d2_reg <= 60'(sqx_reg) + 60'(sqy_reg) + 60'(sqz_reg);
            end
            S_E_SQ:
            begin
                esq_reg <= 40'(edge_q) * 40'(edge_q);
            end
            S_A_1:
            begin
                a1_reg <= 14'(e_cnt_reg[5:0]) * 14'(first_bins_reg) + 14'(b1);
            end
            S_A_2:
            begin
                a2_reg <= 22'(a1_reg) * 22'(second_bins_reg) + 22'(b2);
            end
            S_A_3:
            begin
                a3_reg <= 30'(a2_reg) * 30'(nd) + 30'(dbin_q);
            end
            default: ;
        endcase
    end

    // Search sequencer: per grid point, first a distance bin for every tank,
    // then one table sum per energy bin, each compared against the best so far.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            nt_reg     <= '0;
            ng_reg     <= '0;
            g_cnt_reg  <= '0;
            t_cnt_reg  <= '0;
            e_cnt_reg  <= '0;
            bin_reg    <= '0;
            sum_reg    <= '0;
            best_reg   <= '0;
            best_g_reg <= '0;
            best_e_reg <= '0;
            found_reg  <= 1'b0;
            ierr_reg   <= 1'b0;
            done_reg   <= 1'b0;
            result_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept && (item.req_type == REQ_START))
                    begin
                        nt_reg     <= nt_start;
                        ng_reg     <= ng_start;
                        g_cnt_reg  <= '0;
                        t_cnt_reg  <= '0;
                        best_reg   <= '0;
                        best_g_reg <= '0;
                        best_e_reg <= '0;
                        found_reg  <= 1'b0;
                        ierr_reg   <= 1'b0;
                        if ((ng_start == 11'd0) || (ne == 7'd0))
                        begin
                            state_reg <= S_FINISH;
                        end
                        else
                        begin
                            state_reg <= S_G_LOAD;
                        end
                    end
                end
                S_G_LOAD:
                begin
                    // With no tanks every energy bin sums to zero.
                    if (nt_reg == 8'd0)
                    begin
                        e_cnt_reg <= '0;
                        sum_reg   <= '0;
                        state_reg <= S_BEST;
                    end
                    else
                    begin
                        state_reg <= S_T_H;
                    end
                end
                S_T_RD:  state_reg <= S_T_H;
                S_T_H:   state_reg <= S_T_P1;
                S_T_P1:  state_reg <= S_T_S;
                S_T_S:   state_reg <= S_T_P2;
                S_T_P2:  state_reg <= S_T_W;
                S_T_W:   state_reg <= S_T_SQ;
                S_T_SQ:  state_reg <= S_T_D;
                S_T_D:
                begin
                    bin_reg <= '0;
                    if (nd > 6'd1)
                    begin
                        state_reg <= S_E_RD;
                    end
                    else
                    begin
                        state_reg <= S_T_WR;
                    end
                end
                S_E_RD:  state_reg <= S_E_SQ;
                S_E_SQ:  state_reg <= S_E_CMP;
                S_E_CMP:
                begin
                    // Step up one bin while the distance lies beyond the next edge.
                    if (d2_reg > 60'(esq_reg))
                    begin
                        bin_reg <= bin_reg + DBIN_W'(1);
                        if ((6'(bin_reg) + 6'd2) < nd)
                        begin
                            state_reg <= S_E_RD;
                        end
                        else
                        begin
                            state_reg <= S_T_WR;
                        end
                    end
                    else
                    begin
                        state_reg <= S_T_WR;
                    end
                end
                S_T_WR:
                begin
                    if ((t_cnt_reg + 8'd1) < nt_reg)
                    begin
                        t_cnt_reg <= t_cnt_reg + 8'd1;
                        state_reg <= S_T_RD;
                    end
                    else
                    begin
                        t_cnt_reg <= '0;
                        e_cnt_reg <= '0;
                        sum_reg   <= '0;
                        state_reg <= S_A_RD;
                    end
                end
                S_A_RD:  state_reg <= S_A_1;
                S_A_1:   state_reg <= S_A_2;
                S_A_2:   state_reg <= S_A_3;
                S_A_3:   state_reg <= S_L_RD;
                S_L_RD:  state_reg <= S_L_ACC;
                S_L_ACC:
                begin
                    // An index past the table adds nothing and flags the result.
                    if (a3_reg < 30'(TABLE_DEPTH))
                    begin
                        sum_reg <= sum_reg + 40'(llh_q);
                    end
                    else
                    begin
                        ierr_reg <= 1'b1;
                    end
                    if ((t_cnt_reg + 8'd1) < nt_reg)
                    begin
                        t_cnt_reg <= t_cnt_reg + 8'd1;
                        state_reg <= S_A_RD;
                    end
                    else
                    begin
                        state_reg <= S_BEST;
                    end
                end
                S_BEST:
                begin
                    // Strict compare keeps the first maximum.
                    if (!found_reg || (sum_reg > best_reg))
                    begin
                        found_reg  <= 1'b1;
                        best_reg   <= sum_reg;
                        best_g_reg <= g_cnt_reg[GRID_AW-1:0];
                        best_e_reg <= e_cnt_reg[5:0];
                    end
                    t_cnt_reg <= '0;
                    sum_reg   <= '0;
                    if ((e_cnt_reg + 7'd1) < ne)
                    begin
                        e_cnt_reg <= e_cnt_reg + 7'd1;
                        if (nt_reg == 8'd0)
                        begin
                            state_reg <= S_BEST;
                        end
                        else
                        begin
                            state_reg <= S_A_RD;
                        end
                    end
                    else if ((g_cnt_reg + 11'd1) < ng_reg)
                    begin
                        g_cnt_reg <= g_cnt_reg + 11'd1;
                        state_reg <= S_G_LOAD;
                    end
                    else
                    begin
                        state_reg <= S_FINISH;
                    end
                end
                S_FINISH:
                begin
                    done_reg                   <= 1'b1;
                    result_reg.best_llh        <= best_reg;
                    result_reg.best_grid_index <= best_g_reg;
                    result_reg.best_energy_bin <= best_e_reg;
                    result_reg.found           <= found_reg;
                    result_reg.index_error     <= ierr_reg;
                    state_reg                  <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

>>> rtl/lgs_checker.sv
`include "likelihood_grid_search_unit_assert.svh"

module lgs_checker
    import lgs_pkg::*;
(
    input logic     clk,
    input logic     rst_n,
    input logic     start,
    input lgs_in_t  item,
    input logic     busy,
    input logic     done,
    input lgs_out_t result
);

    // A result only appears once the search has released the unit.
    `LGS_ASSERT_SAME(a_done_idle, done, !busy, "result shown while busy")

    // The result strobe lasts a single cycle.
    `LGS_ASSERT_NEXT(a_done_pulse, done, !done, "result strobe held longer than one cycle")

    // A start item always occupies the unit in the next cycle.
    `LGS_ASSERT_NEXT(a_start_busy, start && !busy && (item.req_type == REQ_START), busy,
        "start item did not begin a search")

    // Load items complete in the cycle they are taken and produce no result.
    `LGS_ASSERT_NEXT(a_load_quiet, start && !busy && (item.req_type != REQ_START),
        !busy && !done, "load item disturbed the unit")

    // An empty search reports all zero fields.
    `LGS_ASSERT_SAME(a_empty_zero, done && !result.found,
        (result.best_llh == 40'sd0) && (result.best_grid_index == 10'd0)
        && (result.best_energy_bin == 6'd0), "empty search reported nonzero fields")

endmodule

bind likelihood_grid_search_unit lgs_checker u_lgs_checker (.*);

>>> bench/tb.sv
`timescale 1ns / 1ps

module tb;
    import lgs_pkg::*;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    lgs_in_t     item = '0;
    logic        busy;
    logic        done;
    lgs_out_t    result;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = 3'd0;
    logic [15:0] cfg_data = 16'd0;

    // Count of accepted input items; the random part stops once it is reached.
    int unsigned items_sent = 0;
    // When set, the sender issues items back to back with no gaps.
    bit burst = 1'b0;

    always #10 clk = ~clk;

    likelihood_grid_search_unit u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .item      (item),
        .busy      (busy),
        .done      (done),
        .result    (result),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // The scoreboard keeps its own copy of every store and register of the unit.
    // Each accepted item updates that copy; a start item computes the expected
    // best match, which waits in a queue until the unit reports its result.
    class search_scoreboard;
        logic [31:0]        llh_mem [longint];
        logic [19:0]        edge_mem [EDGE_DEPTH];
        logic signed [19:0] tank_x [MAX_TANKS];
        logic signed [19:0] tank_y [MAX_TANKS];
        logic signed [19:0] tank_z [MAX_TANKS];
        logic [5:0]         tank_b1 [MAX_TANKS];
        logic [5:0]         tank_b2 [MAX_TANKS];
        bit                 tank_set [MAX_TANKS];
        logic signed [19:0] grid_x [MAX_GRID];
        logic signed [19:0] grid_y [MAX_GRID];
        bit                 grid_set [MAX_GRID];
        logic [6:0]         n_energy = 7'd1;
        logic [6:0]         n_first = 7'd1;
        logic [6:0]         n_second = 7'd1;
        logic [5:0]         n_dist = 6'd1;
        logic signed [15:0] dir_x = 16'sd0;
        logic signed [15:0] dir_y = 16'sd0;
        logic signed [15:0] dir_z = -16'sd16384;
        lgs_out_t           expected_best [$];
        int                 errors = 0;

        function void set_reg(cfg_t idx, logic [15:0] v);
            case (idx)
                CFG_ENERGY_BINS:   n_energy = v[6:0];
                CFG_FIRST_BINS:    n_first = v[6:0];
                CFG_SECOND_BINS:   n_second = v[6:0];
                CFG_DISTANCE_BINS: n_dist = v[5:0];
                CFG_DIR_X:         dir_x = v;
                CFG_DIR_Y:         dir_y = v;
                CFG_DIR_Z:         dir_z = v;
                default: ;
            endcase
        endfunction

        function int dist_count();
            if (n_dist == 0)
                return 1;
            if (n_dist > MAX_DIST_BINS)
                return MAX_DIST_BINS;
            return n_dist;
        endfunction

        // Divide by 2^14 with rounding half up; the arithmetic shift floors.
        function longint round_q14(longint x);
            return (x + ROUND_HALF) >>> FRAC_BITS;
        endfunction

        // Closest approach of the axis through grid point (gx, gy) at the fixed
        // height to tank t, compared as a square against the squared edges.
        function int dist_bin(int t, longint gx, longint gy, int nd);
            longint hx, hy, hz, s, wx, wy, wz, d2, e;
            int bin;
            hx = gx - longint'(tank_x[t]);
            hy = gy - longint'(tank_y[t]);
            hz = longint'(GRID_HEIGHT) - longint'(tank_z[t]);
            s = round_q14(longint'(dir_x) * hx + longint'(dir_y) * hy
                          + longint'(dir_z) * hz);
            wx = round_q14(s * longint'(dir_x) - hx * 16384);
            wy = round_q14(s * longint'(dir_y) - hy * 16384);
            wz = round_q14(s * longint'(dir_z) - hz * 16384);
            d2 = wx * wx + wy * wy + wz * wz;
            bin = 0;
            while (bin + 1 < nd) begin
                e = longint'(edge_mem[bin + 1]);
                if (d2 > e * e)
                    bin++;
                else
                    break;
            end
            return bin;
        endfunction

        // Runs the whole search. With collect set, table words that were never
        // loaded are listed in missing so the driver can load them first.
        function lgs_out_t search(lgs_in_t it, bit collect, ref longint missing[$]);
            lgs_out_t r;
            int nd, ne, nt, ng, best_g, best_e;
            int dbin [MAX_TANKS];
            longint a, sum, best;
            bit hit, ierr;
            nd = dist_count();
            ne = (n_energy > MAX_ENERGY) ? MAX_ENERGY : n_energy;
            nt = (it.tank_count > MAX_TANKS) ? MAX_TANKS : it.tank_count;
            ng = (it.grid_count > MAX_GRID) ? MAX_GRID : it.grid_count;
            hit = 0;
            ierr = 0;
            best = 0;
            best_g = 0;
            best_e = 0;
            for (int g = 0; g < ng; g++) begin
                for (int t = 0; t < nt; t++)
                    dbin[t] = dist_bin(t, grid_x[g], grid_y[g], nd);
                for (int e = 0; e < ne; e++) begin
                    sum = 0;
                    for (int t = 0; t < nt; t++) begin
                        a = ((longint'(e) * n_first + tank_b1[t]) * n_second
                             + tank_b2[t]) * nd + dbin[t];
                        if (a >= TABLE_DEPTH)
                            ierr = 1;
                        else if (llh_mem.exists(a))
                            sum += longint'(signed'(llh_mem[a]));
                        else if (collect)
                            missing = {missing, a};
                    end
                    if (!hit || sum > best) begin
                        hit = 1;
                        best = sum;
                        best_g = g;
                        best_e = e;
                    end
                end
            end
            if (best > (64'sd1 <<< 39) - 1)
                best = (64'sd1 <<< 39) - 1;
            if (best < -(64'sd1 <<< 39))
                best = -(64'sd1 <<< 39);
            r.best_llh = best[39:0];
            r.best_grid_index = best_g[9:0];
            r.best_energy_bin = best_e[5:0];
            r.found = hit;
            r.index_error = ierr;
            return r;
        endfunction

        function void note_item(lgs_in_t it);
            longint none [$];
            case (it.req_type)
                REQ_TABLE:
                    llh_mem[longint'(it.item_index)] = it.llh_value;
                REQ_EDGE:
                    if (it.item_index < EDGE_DEPTH)
                        edge_mem[it.item_index] = it.edge_value;
                REQ_TANK:
                    if (it.item_index < MAX_TANKS) begin
                        tank_x[it.item_index] = it.pos_x;
                        tank_y[it.item_index] = it.pos_y;
                        tank_z[it.item_index] = it.pos_z;
                        tank_b1[it.item_index] = it.tank_bin_one;
                        tank_b2[it.item_index] = it.tank_bin_two;
                        tank_set[it.item_index] = 1;
                    end
                REQ_GRID:
                    if (it.item_index < MAX_GRID) begin
                        grid_x[it.item_index] = it.pos_x;
                        grid_y[it.item_index] = it.pos_y;
                        grid_set[it.item_index] = 1;
                    end
                REQ_START:
                    expected_best = {expected_best, search(it, 0, none)};
                default: ;
            endcase
        endfunction

        function void check_result(lgs_out_t r);
            lgs_out_t x;
            if (expected_best.size() == 0) begin
                $error("result with no search pending: %p", r);
                errors++;
                return;
            end
            x = expected_best.pop_front();
            if (r.best_llh !== x.best_llh) begin
                $error("best_llh expected %0d actual %0d", x.best_llh, r.best_llh);
                errors++;
            end
            if (r.best_grid_index !== x.best_grid_index) begin
                $error("best_grid_index expected %0d actual %0d",
                       x.best_grid_index, r.best_grid_index);
                errors++;
            end
            if (r.best_energy_bin !== x.best_energy_bin) begin
                $error("best_energy_bin expected %0d actual %0d",
                       x.best_energy_bin, r.best_energy_bin);
                errors++;
            end
            if (r.found !== x.found) begin
                $error("found expected %0b actual %0b", x.found, r.found);
                errors++;
            end
            if (r.index_error !== x.index_error) begin
                $error("index_error expected %0b actual %0b", x.index_error, r.index_error);
                errors++;
            end
        endfunction
    endclass

    search_scoreboard sb = new();

    // Results cannot be held off, so every cycle with done high is checked.
    always @(posedge clk)
    begin
        if (rst_n && done)
            sb.check_result(result);
    end

    // A fully random item; callers override the fields that matter.
    function automatic lgs_in_t noise_item();
        logic [191:0] raw;
        raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
        return raw[$bits(lgs_in_t)-1:0];
    endfunction

    // Position that is mostly within 16384 of zero, sometimes anywhere.
    function automatic logic [19:0] pick_pos();
        if ($urandom_range(0, 7) == 0)
            return 20'($urandom);
        return 20'($signed($urandom_range(0, 32768)) - 16384);
    endfunction

    // Drives one item after a random gap (none in burst mode) and returns at the edge that takes it.
    task automatic send_item(input lgs_in_t it);
        int gap;
        gap = burst ? 0 : $urandom_range(0, 10);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item <= it;
        start <= 1'b1;
        do @(posedge clk); while (busy);
        sb.note_item(it);
        items_sent++;
    endtask

    // Leaves valid high; the caller drops it after the last write of a group.
    task automatic write_reg(input cfg_t idx, input logic [15:0] v);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= v;
        do @(posedge clk); while (!cfg_ready);
        sb.set_reg(idx, v);
    endtask

    task automatic load_table(input longint addr, input logic [31:0] v);
        lgs_in_t it;
        it = noise_item();
        it.req_type = REQ_TABLE;
        it.item_index = addr[15:0];
        it.llh_value = v;
        send_item(it);
    endtask

    task automatic load_edge(input int idx, input logic [19:0] v);
        lgs_in_t it;
        it = noise_item();
        it.req_type = REQ_EDGE;
        it.item_index = idx[15:0];
        it.edge_value = v;
        send_item(it);
    endtask

    task automatic load_point(input req_t kind, input int idx);
        lgs_in_t it;
        it = noise_item();
        it.req_type = kind;
        it.item_index = idx[15:0];
        it.pos_x = pick_pos();
        it.pos_y = pick_pos();
        it.pos_z = pick_pos();
        send_item(it);
    endtask

    // Table words are mostly random; a small range makes ties between sums likely.
    function automatic logic [31:0] pick_llh();
        if ($urandom_range(0, 2) == 0)
            return 32'($signed($urandom_range(0, 6)) - 3);
        return $urandom;
    endfunction

    // Loads the tanks, grid points and table words the search will read that were never written, then starts it.
    task automatic run_search(input int tanks, input int points);
        lgs_in_t it;
        longint missing [$];
        int nt, ng;
        nt = (tanks > MAX_TANKS) ? MAX_TANKS : tanks;
        ng = (points > MAX_GRID) ? MAX_GRID : points;
        for (int t = 0; t < nt; t++)
            if (!sb.tank_set[t])
                load_point(REQ_TANK, t);
        for (int g = 0; g < ng; g++)
            if (!sb.grid_set[g])
                load_point(REQ_GRID, g);
        it = noise_item();
        it.req_type = REQ_START;
        it.tank_count = tanks[7:0];
        it.grid_count = points[10:0];
        void'(sb.search(it, 1, missing));
        foreach (missing[i])
            if (!sb.llh_mem.exists(missing[i]))
                load_table(missing[i], pick_llh());
        send_item(it);
    endtask

    // Waits until every search has reported and the unit has settled.
    task automatic drain();
        start <= 1'b0;
        while (sb.expected_best.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    function automatic logic [15:0] pick_count(input int hi);
        case ($urandom_range(0, 9))
            0: return 16'd0;
            1: return 16'(hi);
            2: return 16'd64;
            default: return 16'($urandom_range(1, 6));
        endcase
    endfunction

    function automatic logic [15:0] pick_dir();
        case ($urandom_range(0, 9))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'hc000;
            3: return 16'h4000;
            4: return 16'h0000;
            default: return 16'($signed($urandom_range(0, 32768)) - 16384);
        endcase
    endfunction

    initial begin
        #(400_000_000);
        $display("[likelihood_grid_search_unit] ERROR");
        $finish;
    end

    initial begin
        lgs_in_t it;
        int nt_hi, ng_hi;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part under the reset configuration. All edges are loaded
        // first so that no search ever reads an unwritten edge.
        for (int i = 0; i < EDGE_DEPTH; i++)
            load_edge(i, 20'(i * 200));
        load_table(0, 32'h7fffffff);
        load_table(65535, 32'h80000000);
        load_edge(EDGE_DEPTH, 20'hfffff);
        load_edge(65535, 20'hfffff);
        load_point(REQ_TANK, MAX_TANKS);
        load_point(REQ_GRID, MAX_GRID);
        load_point(REQ_GRID, 65535);
        for (int k = 5; k < 8; k++) begin
            it = noise_item();
            it.req_type = k[2:0];
            send_item(it);
        end
        it = noise_item();
        it.req_type = REQ_TANK;
        it.item_index = 0;
        it.pos_x = 20'h80000;
        it.pos_y = 20'h7ffff;
        it.pos_z = 20'h80000;
        it.tank_bin_one = 6'd63;
        it.tank_bin_two = 6'd63;
        send_item(it);
        it.item_index = 1;
        it.pos_x = 20'h7ffff;
        it.pos_y = 20'h80000;
        it.pos_z = 20'h7ffff;
        it.tank_bin_one = 6'd0;
        it.tank_bin_two = 6'd0;
        send_item(it);
        run_search(0, 0);
        run_search(2, 0);
        run_search(0, 3);
        run_search(2, 1);
        run_search(255, 1);
        run_search(0, 2047);
        drain();

        // Random phases: a fresh configuration, then a mix of loads and searches.
        while (items_sent < 1750) begin
            write_reg(CFG_ENERGY_BINS, pick_count(127));
            write_reg(CFG_FIRST_BINS, pick_count(127));
            write_reg(CFG_SECOND_BINS, pick_count(127));
            write_reg(CFG_DISTANCE_BINS, pick_count(63));
            write_reg(CFG_DIR_X, pick_dir());
            write_reg(CFG_DIR_Y, pick_dir());
            write_reg(CFG_DIR_Z, pick_dir());
            cfg_valid <= 1'b0;
            burst = ($urandom_range(0, 3) == 0);
            // Wide energy sweeps get few tanks and points to bound the run time.
            nt_hi = (sb.n_energy > 8) ? 3 : 6;
            ng_hi = (sb.n_energy > 8) ? 2 : 5;
            for (int n = 0; (n < 40) && (items_sent < 1750); n++) begin
                case ($urandom_range(0, 19))
                    0, 1, 2, 3, 4:
                        load_table($urandom_range(0, 65535), pick_llh());
                    5, 6:
                        load_edge($urandom_range(0, 40),
                                  ($urandom_range(0, 7) == 0) ? 20'($urandom)
                                                              : 20'($urandom_range(0, 8000)));
                    7, 8, 9:
                        load_point(REQ_TANK, ($urandom_range(0, 9) == 0)
                                             ? $urandom_range(0, 65535)
                                             : $urandom_range(0, 7));
                    10, 11:
                        load_point(REQ_GRID, ($urandom_range(0, 9) == 0)
                                             ? $urandom_range(0, 65535)
                                             : $urandom_range(0, 7));
                    12: begin
                        it = noise_item();
                        it.req_type = 3'($urandom_range(5, 7));
                        send_item(it);
                    end
                    default:
                        run_search($urandom_range(0, nt_hi), $urandom_range(0, ng_hi));
                endcase
            end
            drain();
        end

        drain();
        repeat (50) @(posedge clk);
        if (sb.errors == 0)
            $display("[likelihood_grid_search_unit] OK");
        else
            $display("[likelihood_grid_search_unit] ERROR");
        $finish;
    end

endmodule
